FILE: design/lwmal_pkg.sv
// Package for the longest window mean block: widths, depths, payload types
// and the sequencer state type. No dependencies.
package lwmal_pkg;

    localparam int MAX_ITEMS   = 4096;
    localparam int SAMPLE_BITS = 16;

    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ELEM_W = SAMPLE_BITS + 2;
    localparam int SUM_W  = ELEM_W + ADDR_W;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [ELEM_W-1:0]      t_elem;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef logic        [CNT_W-1:0]       t_cnt;
    typedef logic        [ADDR_W-1:0]      t_addr;

    // One stacked prefix minimum: its index and its prefix value.
    typedef struct packed {
        t_cnt idx;
        t_sum val;
    } t_stk_entry;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PRIME,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

FILE: design/lwmal_in_if.sv
// Request channel of the longest window mean block: one sample and its
// end-of-sequence mark. Depends on lwmal_pkg.
interface lwmal_in_if;
    logic               valid;
    logic               ready;
    lwmal_pkg::t_sample sample;
    logic               last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

FILE: design/lwmal_out_if.sv
// Result channel of the longest window mean block: run length and the
// dropped-sample flag. Depends on lwmal_pkg.
interface lwmal_out_if;
    logic            valid;
    logic            ready;
    lwmal_pkg::t_cnt longest_length;
    logic            overflowed;

    modport source (output valid, output longest_length, output overflowed, input ready);
    modport sink   (input valid, input longest_length, input overflowed, output ready);
endinterface

FILE: design/longest_window_mean_at_least.sv
// Top level of the longest window mean block; uses lwmal_pkg, lwmal_in_if and lwmal_out_if.
// Loading: one request per cycle; each one within capacity is written to the prefix memory in its own cycle.
// Scan after the last request: a priming state, then each scan step either moves the right
// end or pops the stack, one at a time as set by the single read port of each memory;
// the done state hands the result to the output register once that register is free.
// Reset (synchronous, active low) clears the sequence state and threshold; memories keep data.
module longest_window_mean_at_least (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  lwmal_pkg::t_sample i_cfg_wdata,
    lwmal_in_if.sink      i_req,
    lwmal_out_if.source   o_res
);
    import lwmal_pkg::*;

    // Sequence state. The stack count includes the implicit base entry
    // (index 0, prefix 0), which lives outside the stack memory.
    t_state  r_state, n_state;
    t_cnt    r_cnt, n_cnt;          // item count while loading, right end j while scanning
    t_cnt    r_top, n_top;          // stack entries including the base
    t_sum    r_sum, n_sum;          // running prefix sum
    t_sum    r_min, n_min;          // value of the current stack top while loading
    logic    r_ovf, n_ovf;
    t_cnt    r_best, n_best;
    t_sample r_thr;

    // Output register
    logic    r_out_valid, n_out_valid;
    t_cnt    r_out_len, n_out_len;
    logic    r_out_ovf, n_out_ovf;

    // Memories: prefix P[1..MAX] at address j-1, stack positions 1..MAX at position-1.
    t_sum       prefix_mem [MAX_ITEMS];
    t_stk_entry stack_mem  [MAX_ITEMS];
    t_sum       r_pre_q;
    t_stk_entry r_stk_q;
    logic       r_base_q;

    logic       pre_we, stk_we;
    t_addr      pre_wr_addr, stk_wr_addr, pre_rd_addr, stk_rd_addr;
    t_stk_entry stk_wdata;

    t_elem      elem;
    t_sum       sum_new;
    t_stk_entry top_entry;
    logic       accept;
    logic       out_free;
    t_cnt       span;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_res.ready;

    // Element e = -sample - threshold, then the next prefix sum.
    assign elem    = -t_elem'(i_req.sample) - t_elem'(r_thr);
    assign sum_new = r_sum + t_sum'(elem);

    // Stack top as seen by the scan: the base entry when only it remains.
    assign top_entry = r_base_q ? t_stk_entry'('0) : r_stk_q;
    assign span      = r_cnt - top_entry.idx;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_top       = r_top;
        n_sum       = r_sum;
        n_min       = r_min;
        n_ovf       = r_ovf;
        n_best      = r_best;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_len   = r_out_len;
        n_out_ovf   = r_out_ovf;
        pre_we      = 1'b0;
        stk_we      = 1'b0;
        pre_wr_addr = r_cnt[ADDR_W-1:0];
        stk_wr_addr = t_addr'(r_top - t_cnt'(1));
        stk_wdata   = '{idx: r_cnt + t_cnt'(1), val: sum_new};
        i_req.ready = 1'b0;

        case (r_state)
            ST_LOAD: begin
                // ready is high throughout loading, so valid alone marks acceptance
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    if (r_cnt != t_cnt'(MAX_ITEMS)) begin
                        // store the prefix; push it if it is a strict new minimum
                        pre_we = 1'b1;
                        n_sum  = sum_new;
                        n_cnt  = r_cnt + t_cnt'(1);
                        if (sum_new < r_min) begin
                            stk_we = 1'b1;
                            n_top  = r_top + t_cnt'(1);
                            n_min  = sum_new;
                        end
                    end else begin
                        // capacity full: drop the sample and flag it
                        n_ovf = 1'b1;
                    end
                    if (i_req.last) begin
                        n_state = ST_PRIME;
                    end
                end
            end
            ST_PRIME: begin
                // reads of P[j] and the stack top are issued below
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_pre_q >= top_entry.val) begin
                    // pop the minimum and hold j
                    if (r_cnt > top_entry.idx && span > r_best) begin
                        n_best = span;
                    end
                    n_top = r_top - t_cnt'(1);
                    if (n_top == '0) begin
                        n_state = ST_DONE;
                    end
                end else begin
                    // advance the right end
                    n_cnt = r_cnt - t_cnt'(1);
                    if (n_cnt == '0) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_len   = r_best;
                    n_out_ovf   = r_ovf;
                    // return the sequence state to its cleared form
                    n_cnt   = '0;
                    n_top   = t_cnt'(1);
                    n_sum   = '0;
                    n_min   = '0;
                    n_ovf   = 1'b0;
                    n_best  = '0;
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        // Read addresses follow the next state: P[j] and the stack top position.
        pre_rd_addr = t_addr'(n_cnt - t_cnt'(1));
        stk_rd_addr = t_addr'(n_top - t_cnt'(2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cnt       <= '0;
            r_top       <= t_cnt'(1);
            r_sum       <= '0;
            r_min       <= '0;
            r_ovf       <= 1'b0;
            r_best      <= '0;
            r_thr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_top       <= n_top;
            r_sum       <= n_sum;
            r_min       <= n_min;
            r_ovf       <= n_ovf;
            r_best      <= n_best;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    // Output payload holds no reset.
    always_ff @(posedge i_clk) begin
        r_out_len <= n_out_len;
        r_out_ovf <= n_out_ovf;
    end

    // Prefix memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (pre_we) begin
            prefix_mem[pre_wr_addr] <= sum_new;
        end
        r_pre_q <= prefix_mem[pre_rd_addr];
    end

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stack_mem[stk_wr_addr] <= stk_wdata;
        end
        r_stk_q  <= stack_mem[stk_rd_addr];
        r_base_q <= (n_top == t_cnt'(1));
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.longest_length = r_out_len;
    assign o_res.overflowed     = r_out_ovf;

    // The base entry is never popped while loading.
    a_base_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOAD |-> r_top != '0)
        else $error("stack lost its base entry while loading");

    // The stack never holds more entries than there are prefixes.
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOAD |-> r_top <= r_cnt + t_cnt'(1))
        else $error("stack deeper than stored prefixes");

    // A scan always has a right end to work on.
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_cnt != '0 && r_top != '0)
        else $error("scan running with nothing to scan");

    // A request arriving at full capacity is flagged.
    a_drop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_cnt == t_cnt'(MAX_ITEMS)) |=> r_ovf)
        else $error("dropped request not flagged");

    // The best length never exceeds the capacity of the store.
    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE |-> r_best <= t_cnt'(MAX_ITEMS))
        else $error("run length beyond capacity");
endmodule

FILE: test/tb_longest_window_mean_at_least.sv
`timescale 1ns / 100ps
// Testbench for longest_window_mean_at_least: directed and random request sequences,
// each result checked against a built-in model of the longest nonnegative-sum run.
// Depends on lwmal_pkg, lwmal_in_if, lwmal_out_if and the block itself.
module tb_longest_window_mean_at_least;
    import lwmal_pkg::*;

    // Idle cycles allowed after the last result before the threshold is touched.
    localparam int SETTLE_CYCLES = 16;
    // Worst drain: a full scan plus long output stalls.
    localparam int DRAIN_LIMIT   = 4 * MAX_ITEMS + 4000;
    localparam int RANDOM_ITEMS  = 500;

    typedef struct {
        t_cnt length;
        logic dropped;
    } t_run_result;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_cfg_we;
    t_sample i_cfg_wdata;

    lwmal_in_if  req_ch ();
    lwmal_out_if res_ch ();

    longest_window_mean_at_least u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_res       (res_ch)
    );

    // Model state: prefix sums of the current sequence, the count held, the
    // dropped-sample flag and the threshold as last written.
    longint      prefix_sums [0:MAX_ITEMS];
    longint      right_peak  [0:MAX_ITEMS];
    longint      run_total       = 0;
    int          held_count      = 0;
    logic        drop_seen       = 1'b0;
    longint      model_threshold = 0;
    t_run_result expected_runs [$];
    int          mismatch_count  = 0;

    // Idling knobs, in percent: chance of a gap before a request, and chance
    // that the result side starts a stall on a given cycle.
    int gap_pct    = 0;
    int stall_pct  = 0;
    int stall_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("longest_window_mean_at_least: mismatch");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Longest j - i with P[j] >= P[i], i < j, over P[0..n]. Walk a running
    // left minimum against the suffix maxima; 0 when no such pair exists.
    function automatic int longest_nonneg_run(int n);
        int     lo_idx;
        int     hi_idx;
        int     best;
        longint lo_min;
        best   = 0;
        lo_idx = 0;
        hi_idx = 0;
        lo_min = prefix_sums[0];
        right_peak[n] = prefix_sums[n];
        for (int j = n - 1; j >= 0; j--)
            right_peak[j] = (prefix_sums[j] > right_peak[j+1]) ? prefix_sums[j]
                                                               : right_peak[j+1];
        while (lo_idx <= n && hi_idx <= n) begin
            if (right_peak[hi_idx] >= lo_min) begin
                if (hi_idx - lo_idx > best)
                    best = hi_idx - lo_idx;
                hi_idx++;
            end else begin
                lo_idx++;
                if (lo_idx <= n && prefix_sums[lo_idx] < lo_min)
                    lo_min = prefix_sums[lo_idx];
            end
        end
        return best;
    endfunction

    // Fold one accepted request into the sequence; on the last one, queue the
    // expected run length and start afresh. Past capacity, drop and flag.
    function automatic void fold_sample(t_sample s, logic lst);
        t_run_result r;
        if (held_count < MAX_ITEMS) begin
            run_total = run_total - longint'(s) - model_threshold;
            held_count++;
            prefix_sums[held_count] = run_total;
        end else
            drop_seen = 1'b1;
        if (lst) begin
            r.length  = t_cnt'(longest_nonneg_run(held_count));
            r.dropped = drop_seen;
            expected_runs.push_back(r);
            run_total  = 0;
            held_count = 0;
            drop_seen  = 1'b0;
        end
    endfunction

    function automatic void check_run(t_cnt got_len, logic got_drop);
        t_run_result want;
        if (expected_runs.size() == 0) begin
            $display("%0t: result with none expected: length %0d overflowed %0b",
                     $time, got_len, got_drop);
            mismatch_count++;
        end else begin
            want = expected_runs.pop_front();
            if (got_len !== want.length) begin
                $display("%0t: longest_length expected %0d actual %0d",
                         $time, want.length, got_len);
                mismatch_count++;
            end
            if (got_drop !== want.dropped) begin
                $display("%0t: overflowed expected %0b actual %0b",
                         $time, want.dropped, got_drop);
                mismatch_count++;
            end
        end
    endfunction

    // Sample everything at the rising edge: threshold writes, accepted
    // requests and accepted results, in that order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we === 1'b1)
                model_threshold = longint'(i_cfg_wdata);
            if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
                fold_sample(req_ch.sample, req_ch.last);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
                check_run(res_ch.longest_length, res_ch.overflowed);
        end
    end

    // Result side: hold ready low for random stretches, at the falling edge.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_ch.ready = 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            res_ch.ready = 1'b0;
            stall_left   = pick_gap() - 1;
        end else
            res_ch.ready = 1'b1;
    end

    // Present one request, maybe after a gap filled with junk payload, and
    // hold it until accepted. Return at the falling edge after acceptance,
    // with valid still high so that back-to-back requests stay back-to-back.
    task automatic send_sample(input t_sample s, input logic lst);
        int gap;
        gap = ($urandom_range(0, 99) < gap_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            req_ch.valid  = 1'b0;
            req_ch.sample = t_sample'($urandom);
            req_ch.last   = 1'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid  = 1'b1;
        req_ch.sample = s;
        req_ch.last   = lst;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // Send a whole sequence, marking the final request as last.
    task automatic send_run(input t_sample vals[$]);
        foreach (vals[k])
            send_sample(vals[k], k == vals.size() - 1);
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic wait_idle();
        int waited;
        waited       = 0;
        req_ch.valid = 1'b0;
        while (expected_runs.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (expected_runs.size() != 0) begin
            $display("%0t: %0d expected results never arrived, next length %0d",
                     $time, expected_runs.size(), expected_runs[0].length);
            mismatch_count += expected_runs.size();
            expected_runs.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Only ever called with the block idle.
    task automatic write_threshold(input t_sample value);
        i_cfg_wdata = value;
        i_cfg_we    = 1'b1;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_wdata = t_sample'($urandom);
    endtask

    // Random sample: extremes, full range, or close to minus the threshold
    // so that elements hover around zero and runs get interesting lengths.
    function automatic t_sample pick_sample(t_sample thr);
        longint v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 1) ? 32767 : -32768;
            1, 2, 3, 4: v = longint'(t_sample'($urandom));
            default: v = -longint'(thr) + longint'($urandom_range(0, 128)) - 64;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return t_sample'(v);
    endfunction

    // Single-request sequences at the sample extremes, a wholly nonnegative
    // sequence, a mixed one, and the threshold at both of its extremes.
    task automatic test_directed_extremes();
        gap_pct   = 0;
        stall_pct = 0;
        // Threshold is still at its reset value of zero here.
        send_run('{-32768});
        send_run('{32767});
        send_run('{0});
        send_run('{-1, -1, -1, -1});
        send_run('{5, -3, -3, 7, -1});
        wait_idle();
        write_threshold(32767);
        send_run('{-32768, -32767, 0});
        wait_idle();
        write_threshold(-32768);
        send_run('{32767, 32767});
        send_run('{-32768});
        wait_idle();
    endtask

    // Overrun the store: the surplus requests, the last one included, are
    // dropped and flagged, and the scan still covers what was held. A short
    // sequence after it must come back with the flag clear.
    task automatic test_dropped_samples();
        gap_pct   = 3;
        stall_pct = 20;
        write_threshold(0);
        for (int k = 0; k < MAX_ITEMS + 3; k++)
            send_sample(pick_sample(0), k == MAX_ITEMS + 2);
        send_run('{7, -9});
        wait_idle();
    endtask

    // Phases of short random sequences, each under its own threshold and
    // its own idling profile, every fourth phase with no idling at all.
    task automatic test_random_phases();
        int      sent;
        int      seq_len;
        t_sample thr;
        sent = 0;
        for (int phase = 0; sent < RANDOM_ITEMS; phase++) begin
            case (phase % 6)
                0: thr = -32768;
                1: thr = 32767;
                2: thr = 0;
                4: thr = t_sample'(longint'($urandom_range(0, 400)) - 200);
                default: thr = t_sample'($urandom);
            endcase
            case (phase % 4)
                0: begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1: begin
                    gap_pct   = 30;
                    stall_pct = 20;
                end
                2: begin
                    gap_pct   = 60;
                    stall_pct = 50;
                end
                default: begin
                    gap_pct   = 10;
                    stall_pct = 70;
                end
            endcase
            write_threshold(thr);
            repeat (10) begin
                seq_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                       : $urandom_range(13, 64);
                for (int k = 0; k < seq_len; k++)
                    send_sample(pick_sample(thr), k == seq_len - 1);
                sent += seq_len;
            end
            wait_idle();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        req_ch.valid  = 1'b0;
        req_ch.sample = '0;
        req_ch.last   = 1'b0;
        res_ch.ready  = 1'b0;
        prefix_sums[0] = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_extremes();
        test_dropped_samples();
        test_random_phases();
        wait_idle();

        if (mismatch_count == 0)
            $display("longest_window_mean_at_least: match");
        else
            $display("longest_window_mean_at_least: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
design/lwmal_pkg.sv
design/lwmal_in_if.sv
design/lwmal_out_if.sv
design/longest_window_mean_at_least.sv
test/tb_longest_window_mean_at_least.sv
